@@ design/gma_pkg.sv @@
//------------------------------------------------------------------------------
// gma_pkg
// Shared types and constants for the grouped masked aggregator.
//------------------------------------------------------------------------------
package gma_pkg;

   localparam int GROUP_COUNT = 16;
   localparam int GW          = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
   localparam int ACC_W       = 48;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef enum logic [1:0] {
      MODE_SUM  = 2'd0,
      MODE_MEAN = 2'd1,
      MODE_MAX  = 2'd2,
      MODE_MIN  = 2'd3
   } mode_type;

   localparam logic [1:0] REG_MODE = 2'd0;

   typedef struct packed {
      logic signed [31:0] sample;
      logic               keep;
      logic [3:0]         group_id;
      logic signed [31:0] weight_in;
      logic               final_item;
   } req_type;

   typedef struct packed {
      logic [3:0]               group_out;
      logic signed [ACC_W-1:0]  aggregate;
      logic                     final_result;
   } rsp_type;

   // divider handshake
   typedef struct packed {
      logic                    start;
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] wgt;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [ACC_W-1:0] quot;
   } div_rsp_type;

   function automatic logic signed [ACC_W-1:0] start_value(input mode_type m);
      case (m)
         MODE_MAX: start_value = ACC_MIN;
         MODE_MIN: start_value = ACC_MAX;
         default:  start_value = '0;
      endcase
   endfunction

   function automatic logic signed [ACC_W-1:0] clamp49(input logic signed [ACC_W:0] v);
      if (v[ACC_W] != v[ACC_W-1])
         clamp49 = v[ACC_W] ? ACC_MIN : ACC_MAX;
      else
         clamp49 = v[ACC_W-1:0];
   endfunction

endpackage

@@ design/grouped_masked_aggregator_top.sv @@
//------------------------------------------------------------------------------
// grouped_masked_aggregator_top
// Per-group sum / weighted mean / max / min over a request stream, with
// accumulators and weights held in synchronous RAMs.
//------------------------------------------------------------------------------
// A request passes through read, multiply, accumulate and write back; busy is
//   high during that time, so a new request is taken only after write back.
// A final request then emits one result per group, 0..highest seen; in mean
//   mode each result also waits for the 64-step divider.
// After emission, and after reset or a mode write, a clearing pass writes all
//   GROUP_COUNT entries, one per cycle, with busy high.
// Results carry a one-cycle strobe; the receiver cannot stall.
//------------------------------------------------------------------------------
module grouped_masked_aggregator_top
   import gma_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   // result channel
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   // configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_MUL, ST_ACC, ST_WB,
      ST_ERD, ST_EWAIT, ST_EOUT, ST_EDIV
   } state_type;

   state_type state_ff;
   mode_type  mode_ff;
   logic [GW-1:0] addr_ff;      // clear / emit pointer
   logic [GW-1:0] hi_ff;
   req_type       req_ff;
   logic signed [63:0] prod_ff;
   logic               rsp_strobe_ff;
   rsp_type            rsp_ff;
   logic               in_range;

   // RAM ports
   logic                    wr_en;
   logic [GW-1:0]           wr_addr, rd_addr;
   logic [ACC_W-1:0]        acc_wd, wgt_wd, acc_rd, wgt_rd;
   logic signed [ACC_W-1:0] acc_s, wgt_s, smp_ext;
   logic signed [ACC_W-1:0] acc_nxt, wgt_nxt;
   logic signed [63:0]      term;

   div_req_type dreq;
   div_rsp_type drsp;

   logic cfg_wr;
   assign cfg_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;
   assign prdata = {30'd0, mode_ff};

   assign in_range = (32'(req_ff.group_id) < 32'(GROUP_COUNT));
   assign acc_s    = acc_rd;
   assign wgt_s    = wgt_rd;
   assign smp_ext  = ACC_W'(req_ff.sample);
   // floor division by 2^16: arithmetic shift
   assign term     = prod_ff >>> 16;

   always_comb begin
      acc_nxt = acc_s;
      wgt_nxt = wgt_s;
      case (mode_ff)
         MODE_SUM, MODE_MEAN: begin
            if (req_ff.keep) begin
               acc_nxt = clamp49({acc_s[ACC_W-1], acc_s} + (ACC_W+1)'(term));
               wgt_nxt = clamp49({wgt_s[ACC_W-1], wgt_s} + (ACC_W+1)'(req_ff.weight_in));
            end
         end
         MODE_MAX: if (req_ff.keep && smp_ext > acc_s) acc_nxt = smp_ext;
         MODE_MIN: if (req_ff.keep && smp_ext < acc_s) acc_nxt = smp_ext;
         default: ;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      acc_wd  = start_value(mode_ff);
      wgt_wd  = '0;
      rd_addr = addr_ff;
      if (state_ff == ST_CLEAR) begin
         wr_en = 1'b1;
      end else if (state_ff == ST_WB) begin
         wr_en   = in_range;
         wr_addr = GW'(req_ff.group_id);
         acc_wd  = acc_nxt;
         wgt_wd  = wgt_nxt;
      end
      if (state_ff == ST_IDLE) rd_addr = GW'(req_data.group_id);
      else if (state_ff == ST_MUL || state_ff == ST_ACC || state_ff == ST_WB)
         rd_addr = GW'(req_ff.group_id);
   end

   gma_ram #(.WIDTH(ACC_W), .DEPTH(GROUP_COUNT)) u_acc_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(acc_wd),
      .rd_addr(rd_addr), .rd_data(acc_rd));

   gma_ram #(.WIDTH(ACC_W), .DEPTH(GROUP_COUNT)) u_wgt_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wgt_wd),
      .rd_addr(rd_addr), .rd_data(wgt_rd));

   assign dreq.start = (state_ff == ST_EWAIT) && (mode_ff == MODE_MEAN);
   assign dreq.acc   = acc_s;
   assign dreq.wgt   = wgt_s;

   gma_div u_div (.clock(clock), .reset(reset), .dreq(dreq), .drsp(drsp));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         mode_ff       <= MODE_SUM;
         addr_ff       <= '0;
         hi_ff         <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (cfg_wr && paddr == REG_MODE) begin
            // mode write restarts the clearing pass
            mode_ff  <= mode_type'(pwdata[1:0]);
            state_ff <= ST_CLEAR;
            addr_ff  <= '0;
            hi_ff    <= '0;
         end else begin
            case (state_ff)
               ST_CLEAR: begin
                  addr_ff <= addr_ff + 1'b1;
                  hi_ff   <= '0;
                  if (32'(addr_ff) == GROUP_COUNT - 1) begin
                     addr_ff  <= '0;
                     state_ff <= ST_IDLE;
                  end
               end
               ST_IDLE: begin
                  if (start) begin
                     req_ff   <= req_data;
                     state_ff <= ST_MUL;
                  end
               end
               ST_MUL: begin
                  prod_ff  <= req_ff.sample * req_ff.weight_in;
                  state_ff <= ST_ACC;
               end
               ST_ACC: state_ff <= ST_WB;
               ST_WB: begin
                  if (in_range && GW'(req_ff.group_id) > hi_ff)
                     hi_ff <= GW'(req_ff.group_id);
                  addr_ff  <= '0;
                  state_ff <= req_ff.final_item ? ST_ERD : ST_IDLE;
               end
               ST_ERD: state_ff <= ST_EWAIT;
               ST_EWAIT: begin
                  rsp_ff.group_out    <= 4'(addr_ff);
                  rsp_ff.final_result <= (addr_ff == hi_ff);
                  rsp_ff.aggregate    <= acc_s;
                  if (mode_ff == MODE_MEAN) begin
                     state_ff <= ST_EDIV;
                  end else begin
                     rsp_strobe_ff <= 1'b1;
                     state_ff      <= ST_EOUT;
                  end
               end
               ST_EDIV: begin
                  if (drsp.done) begin
                     rsp_ff.aggregate <= drsp.quot;
                     rsp_strobe_ff    <= 1'b1;
                     state_ff         <= ST_EOUT;
                  end
               end
               ST_EOUT: begin
                  if (addr_ff == hi_ff) begin
                     addr_ff  <= '0;
                     state_ff <= ST_CLEAR;
                  end else begin
                     addr_ff  <= addr_ff + 1'b1;
                     state_ff <= ST_ERD;
                  end
               end
               default: state_ff <= ST_CLEAR;
            endcase
         end
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // results only come out during emission
   a_rsp_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (state_ff == ST_EOUT)) else $error("stray result");
   // no request is taken while the store is written
   a_no_take_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> busy) else $error("busy low in clear");
   // emission never passes the highest group seen
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.group_out <= 4'(hi_ff))) else $error("emit past top");

endmodule

@@ design/gma_ram.sv @@
//------------------------------------------------------------------------------
// gma_ram
// Generic single-port-write, single-port-read RAM with registered read data.
//------------------------------------------------------------------------------
module gma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ design/gma_div.sv @@
//------------------------------------------------------------------------------
// gma_div
// Iterative restoring divider for the mean: (acc << 16) / weight, truncated,
// saturated to 48 bits; weight <= 0 gives the positive sentinel.
//------------------------------------------------------------------------------
module gma_div
   import gma_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type dreq,
   output div_rsp_type drsp
);

   localparam int NW = ACC_W + 16;   // dividend width
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0]    num_ff, num_in;
   logic [ACC_W:0]   rem_ff, rem_in;
   logic [ACC_W-1:0] den_ff, den_in;
   logic             neg_ff, neg_in;
   logic             byp_ff, byp_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic signed [ACC_W-1:0] quot_ff, quot_in;

   logic [ACC_W-1:0] mag;
   logic [ACC_W+1:0] trial;
   logic [ACC_W:0]   shifted;

   assign mag = dreq.acc[ACC_W-1] ? (~dreq.acc + 1'b1) : dreq.acc;
   assign shifted = {rem_ff[ACC_W-1:0], num_ff[NW-1]};
   assign trial = {1'b0, shifted} - {2'b00, den_ff};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      byp_in  = byp_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      quot_in = quot_ff;
      if (dreq.start) begin
         num_in  = {mag, 16'h0000};
         rem_in  = '0;
         den_in  = dreq.wgt;
         neg_in  = dreq.acc[ACC_W-1];
         byp_in  = dreq.wgt[ACC_W-1] || (dreq.wgt == '0);
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (byp_ff) begin
            quot_in = ACC_MAX;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (cnt_ff != '0) begin
            // quotient bits shift into num
            if (!trial[ACC_W+1]) begin
               rem_in = trial[ACC_W:0];
               num_in = {num_ff[NW-2:0], 1'b1};
            end else begin
               rem_in = shifted;
               num_in = {num_ff[NW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff) begin
               if (num_ff >= NW'({1'b1, {(ACC_W-1){1'b0}}}))
                  quot_in = ACC_MIN;
               else
                  quot_in = -$signed(num_ff[ACC_W-1:0]);
            end else begin
               if (num_ff > NW'(ACC_MAX))
                  quot_in = ACC_MAX;
               else
                  quot_in = num_ff[ACC_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      byp_ff  <= byp_in;
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
   end

   assign drsp.done = done_ff;
   assign drsp.quot = quot_ff;

endmodule
